/* design/imuagc_pkg.sv */
// shared types and constants for the imu activity and gesture classifier
package imuagc_pkg;

	localparam int CFG_W     = 30;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STILL_VAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_VAR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_VAR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LYING_Z     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_MAG   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAISE_DELTA = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd6;

	// register reset values
	localparam logic [29:0] RST_STILL_VAR   = 30'd335544;
	localparam logic [29:0] RST_WALK_VAR    = 30'd2516582;
	localparam logic [29:0] RST_DRIVE_VAR   = 30'd1342177;
	localparam logic [14:0] RST_LYING_Z     = 15'd2867;
	localparam logic [15:0] RST_SHAKE_MAG   = 16'd10240;
	localparam logic [15:0] RST_RAISE_DELTA = 16'd1638;
	localparam logic [15:0] RST_COOLDOWN    = 16'd800;

	// fixed g thresholds at 4096 lsb per g
	localparam logic [16:0]        G_POINT3     = 17'd1228;
	localparam logic signed [15:0] Z_RAISE_MIN  = 16'sd1228;
	localparam logic signed [15:0] Z_ARM_BELOW  = -16'sd2048;
	localparam logic signed [15:0] X_TILT_RIGHT = 16'sd2867;
	localparam logic signed [15:0] X_TILT_LEFT  = -16'sd2867;

	// square root steps, one result bit from two bits of the radicand each
	localparam logic [3:0] ROOT_LAST = 4'd15;

	typedef enum logic [2:0] {
		ACT_UNKNOWN = 3'd0,
		ACT_STILL   = 3'd1,
		ACT_WALKING = 3'd2,
		ACT_LYING   = 3'd3,
		ACT_DRIVING = 3'd4
	} activity_t;

	typedef enum logic [2:0] {
		GES_NONE        = 3'd0,
		GES_SHAKE       = 3'd1,
		GES_WRIST_RAISE = 3'd2,
		GES_TILT_RIGHT  = 3'd3,
		GES_TILT_LEFT   = 3'd4
	} gesture_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MX, ST_MY, ST_MZ, ST_SQE, ST_ROOT, ST_MAG2, ST_OLD2,
		ST_SUM2, ST_WLO, ST_WHI, ST_LS, ST_LW, ST_LD, ST_FIN, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SQ_END, OP_ROOT, OP_MAG2,
		OP_OLD2, OP_SUM2, OP_W_LO, OP_W_HI, OP_LIM_S, OP_LIM_W, OP_LIM_D,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic take;
		op_t  op;
		logic load_out;
	} cmd_t;

	// activity in the lowest bits
	typedef struct packed {
		gesture_t  gesture;
		logic      changed;
		activity_t activity;
	} result_t;

endpackage

/* design/imu_activity_and_gesture_classifier_unit.sv */
// top level of the imu activity and gesture classifier
//
// channel   dir  width  content
// s_axis    in   80     sample beat: accel_x, accel_y, accel_z, time_ms
// m_axis    out  8      result beat: activity, activity_changed, gesture
// cfg       in   30     register writes, index 0 to 6, no read-back
//
// a sample goes through these steps from acceptance to the next free slot: one accept
// step, three squaring steps on the single 32x32 multiplier and one to add them up,
// 16 square root steps, nine steps of window update and variance tests, one output load.
// the output load step writes the result into the output register that drives m_axis.
// reset clears the window valid bits, running sums and classifier state at once;
// a stalled m_axis holds the result register and the sequencer waits to load it,
// while the previous result already waiting lets the next sample in.
module imu_activity_and_gesture_classifier_unit import imuagc_pkg::*; #(
	parameter int WINDOW_LEN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// accel_x [15:0], accel_y [31:16], accel_z [47:32], time_ms [79:48]
	input  logic [79:0]          s_axis_tdata,
	// result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// activity [2:0], activity_changed [3], gesture [6:4], zero [7]
	output logic [7:0]           m_axis_tdata,
	// register writes
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data
);

	cmd_t    cmd;
	result_t res;
	result_t out_data_q;
	logic    out_valid_q;
	logic    out_free;

	// the output register may take a new beat when empty or drained this cycle
	assign out_free = !out_valid_q || m_axis_tready;

	imuagc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	imuagc_dp #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_x        (s_axis_tdata[15:0]),
		.in_y        (s_axis_tdata[31:16]),
		.in_z        (s_axis_tdata[47:32]),
		.in_time     (s_axis_tdata[79:48]),
		.cmd         (cmd),
		.res         (res)
	);

	// output register, parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_data_q};

`ifndef SYNTHESIS
	// sequencer leaves idle right after taking a sample
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("sample accepted while previous one still in work");

	// a result is never loaded over one that has not been taken
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten");

	// the block only returns to accepting samples after loading a result into the output register
	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> $past(cmd.load_out))
		else $error("ready without a result loaded");
`endif

endmodule

/* design/imuagc_ctrl.sv */
// sequencer for the classifier datapath
module imuagc_ctrl import imuagc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_free,
	output logic in_ready,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [3:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_ROOT) ? cnt_q + 4'd1 : '0;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.op       = OP_IDLE;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_MX;
				end
			end
			ST_MX: begin
				cmd.op  = OP_SQ_X;
				state_d = ST_MY;
			end
			ST_MY: begin
				cmd.op  = OP_SQ_Y;
				state_d = ST_MZ;
			end
			ST_MZ: begin
				cmd.op  = OP_SQ_Z;
				state_d = ST_SQE;
			end
			ST_SQE: begin
				cmd.op  = OP_SQ_END;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = OP_ROOT;
				if (cnt_q == ROOT_LAST) begin
					state_d = ST_MAG2;
				end
			end
			ST_MAG2: begin
				cmd.op  = OP_MAG2;
				state_d = ST_OLD2;
			end
			ST_OLD2: begin
				cmd.op  = OP_OLD2;
				state_d = ST_SUM2;
			end
			ST_SUM2: begin
				cmd.op  = OP_SUM2;
				state_d = ST_WLO;
			end
			ST_WLO: begin
				cmd.op  = OP_W_LO;
				state_d = ST_WHI;
			end
			ST_WHI: begin
				cmd.op  = OP_W_HI;
				state_d = ST_LS;
			end
			ST_LS: begin
				cmd.op  = OP_LIM_S;
				state_d = ST_LW;
			end
			ST_LW: begin
				cmd.op  = OP_LIM_W;
				state_d = ST_LD;
			end
			ST_LD: begin
				cmd.op  = OP_LIM_D;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.op  = OP_FINISH;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/imuagc_dp.sv */
// classifier datapath: shared multiplier, square root, window and decision logic
module imuagc_dp import imuagc_pkg::*; #(
	parameter int WINDOW_LEN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic signed [15:0]   in_x,
	input  logic signed [15:0]   in_y,
	input  logic signed [15:0]   in_z,
	input  logic [31:0]          in_time,
	input  cmd_t                 cmd,
	output result_t              res
);

	localparam int CLG   = $clog2(WINDOW_LEN);
	localparam int SUM_W = 16 + CLG;
	localparam int SQS_W = 32 + CLG;
	localparam int SPR_W = 32 + 2 * CLG;
	localparam logic [31:0]    W_C      = 32'(WINDOW_LEN);
	localparam logic [31:0]    W2_C     = 32'(WINDOW_LEN * WINDOW_LEN);
	localparam logic [CLG-1:0] POS_LAST = CLG'(WINDOW_LEN - 1);

	function automatic logic [16:0] abs17(input logic signed [15:0] v);
		logic [16:0] e;
		e = {v[15], v};
		return v[15] ? 17'(-e) : e;
	endfunction

	// configuration
	logic [29:0] still_q, walk_q, drive_q;
	logic [14:0] lying_q;
	logic [15:0] shake_q, raise_d_q, cool_q;

	// sample and working registers
	logic signed [15:0] ax_q, ay_q, az_q;
	logic [31:0]        time_q;
	logic [63:0]        prod_q;
	logic [31:0]        mul_a, mul_b;
	logic [31:0]        rem_q, root_q, bit_q, root_try;
	logic [SPR_W-1:0]   spr_q, lim;
	logic               lt_still_q, gt_walk_q, gt_drive;

	// window and running sums
	logic [15:0]           win_mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] valid_q;
	logic [15:0]           rd_q, old;
	logic                  rd_valid_q;
	logic [CLG-1:0]        pos_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQS_W-1:0]      sqs_q;

	// classification state
	activity_t          cur_act_q, next_act;
	logic [31:0]        last_q, elapsed;
	logic signed [15:0] prev_z_q;
	logic               armed_q, armed_nx, raised, cool_ok, shake, lying;
	logic [16:0]        abs_x, abs_y, abs_z;
	logic signed [17:0] dz;
	gesture_t           ges;
	result_t            res_q;

	assign abs_x    = abs17(ax_q);
	assign abs_y    = abs17(ay_q);
	assign abs_z    = abs17(az_q);
	assign old      = rd_valid_q ? rd_q : 16'd0;
	assign root_try = root_q + bit_q;
	assign lim      = prod_q[SPR_W-1:0];
	assign res      = res_q;

	// one shared multiplier, operands picked per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ_X: begin
				mul_a = 32'(abs_x);
				mul_b = 32'(abs_x);
			end
			OP_SQ_Y: begin
				mul_a = 32'(abs_y);
				mul_b = 32'(abs_y);
			end
			OP_SQ_Z: begin
				mul_a = 32'(abs_z);
				mul_b = 32'(abs_z);
			end
			OP_MAG2: begin
				mul_a = 32'(root_q[15:0]);
				mul_b = 32'(root_q[15:0]);
			end
			OP_OLD2: begin
				mul_a = 32'(old);
				mul_b = 32'(old);
			end
			OP_SUM2: begin
				mul_a = 32'(sum_q);
				mul_b = 32'(sum_q);
			end
			OP_W_LO: begin
				mul_a = W_C;
				mul_b = sqs_q[31:0];
			end
			OP_W_HI: begin
				mul_a = W_C;
				mul_b = 32'(sqs_q[SQS_W-1:32]);
			end
			OP_LIM_S: begin
				mul_a = 32'(still_q);
				mul_b = W2_C;
			end
			OP_LIM_W: begin
				mul_a = 32'(walk_q);
				mul_b = W2_C;
			end
			OP_LIM_D: begin
				mul_a = 32'(drive_q);
				mul_b = W2_C;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// decision logic on the final step
	always_comb begin
		elapsed  = time_q - last_q;
		cool_ok  = elapsed >= 32'(cool_q);
		shake    = root_q[15:0] > shake_q;
		dz       = 18'(az_q) - 18'(prev_z_q);
		armed_nx = armed_q || (az_q < Z_ARM_BELOW);
		raised   = armed_nx && (dz > $signed({2'b00, raise_d_q})) && (az_q > Z_RAISE_MIN);
		gt_drive = spr_q > lim;
		lying    = (abs_z > 17'(lying_q)) && (abs_x <= G_POINT3);

		if (!cool_ok) begin
			ges = GES_NONE;
		end else if (shake) begin
			ges = GES_SHAKE;
		end else if (raised) begin
			ges = GES_WRIST_RAISE;
		end else if (ax_q > X_TILT_RIGHT && abs_y <= G_POINT3) begin
			ges = GES_TILT_RIGHT;
		end else if (ax_q < X_TILT_LEFT && abs_y <= G_POINT3) begin
			ges = GES_TILT_LEFT;
		end else begin
			ges = GES_NONE;
		end

		if (lying) begin
			next_act = ACT_LYING;
		end else if (lt_still_q) begin
			next_act = ACT_STILL;
		end else if (gt_walk_q) begin
			next_act = ACT_WALKING;
		end else if (gt_drive) begin
			next_act = ACT_DRIVING;
		end else begin
			next_act = ACT_STILL;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q   <= RST_STILL_VAR;
			walk_q    <= RST_WALK_VAR;
			drive_q   <= RST_DRIVE_VAR;
			lying_q   <= RST_LYING_Z;
			shake_q   <= RST_SHAKE_MAG;
			raise_d_q <= RST_RAISE_DELTA;
			cool_q    <= RST_COOLDOWN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_STILL_VAR:   still_q   <= cfg_wr_data[29:0];
				CFG_WALK_VAR:    walk_q    <= cfg_wr_data[29:0];
				CFG_DRIVE_VAR:   drive_q   <= cfg_wr_data[29:0];
				CFG_LYING_Z:     lying_q   <= cfg_wr_data[14:0];
				CFG_SHAKE_MAG:   shake_q   <= cfg_wr_data[15:0];
				CFG_RAISE_DELTA: raise_d_q <= cfg_wr_data[15:0];
				CFG_COOLDOWN:    cool_q    <= cfg_wr_data[15:0];
				default: ;
			endcase
		end
	end

	// working registers, rebuilt for every sample
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.take) begin
			ax_q   <= in_x;
			ay_q   <= in_y;
			az_q   <= in_z;
			time_q <= in_time;
			root_q <= '0;
			bit_q  <= 32'h4000_0000;
		end
		case (cmd.op)
			OP_SQ_Y:   rem_q <= prod_q[31:0];
			OP_SQ_Z:   rem_q <= rem_q + prod_q[31:0];
			OP_SQ_END: rem_q <= rem_q + prod_q[31:0];
			OP_ROOT: begin
				if (rem_q >= root_try) begin
					rem_q  <= rem_q - root_try;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_W_LO:  spr_q      <= '0 - prod_q[SPR_W-1:0];
			OP_W_HI:  spr_q      <= spr_q + prod_q[SPR_W-1:0];
			OP_LIM_S: spr_q      <= spr_q + {prod_q[SPR_W-33:0], 32'd0};
			OP_LIM_W: lt_still_q <= spr_q < lim;
			OP_LIM_D: gt_walk_q  <= spr_q > lim;
			OP_FINISH: begin
				res_q.activity <= next_act;
				res_q.changed  <= (next_act != cur_act_q);
				res_q.gesture  <= ges;
			end
			default: ;
		endcase
	end

	// magnitude window store, registered read at the write position
	always_ff @(posedge clk) begin
		rd_q <= win_mem[pos_q];
		if (cmd.op == OP_OLD2) begin
			win_mem[pos_q] <= root_q[15:0];
		end
	end

	// persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			pos_q      <= '0;
			sum_q      <= '0;
			sqs_q      <= '0;
			cur_act_q  <= ACT_UNKNOWN;
			last_q     <= '0;
			prev_z_q   <= '0;
			armed_q    <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[pos_q];
			case (cmd.op)
				OP_OLD2: begin
					sum_q          <= sum_q - SUM_W'(old) + SUM_W'(root_q[15:0]);
					sqs_q          <= sqs_q + prod_q[SQS_W-1:0];
					valid_q[pos_q] <= 1'b1;
					pos_q          <= (pos_q == POS_LAST) ? '0 : pos_q + CLG'(1);
				end
				OP_SUM2: sqs_q <= sqs_q - prod_q[SQS_W-1:0];
				OP_FINISH: begin
					cur_act_q <= next_act;
					if (cool_ok && !shake) begin
						prev_z_q <= az_q;
						armed_q  <= armed_nx && !raised;
					end
					if (ges != GES_NONE) begin
						last_q <= time_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
